### sv/rsgm_pkg.sv
// Shared types and codes for the sequence gap monitor.
// Holds the packet and result records and the gap event codes.
// No dependencies.
package rsgm_pkg;

    // Gap classification of one packet.
    localparam logic [1:0] GAP_NONE  = 2'd0;
    localparam logic [1:0] GAP_LOSSY = 2'd1;
    localparam logic [1:0] GAP_CLEAN = 2'd2;

    // Distance code that marks a duplicate (one behind expected).
    localparam logic [15:0] DIST_DUPLICATE = 16'hFFFF;

    // One received packet as it sits in the input register.
    typedef struct packed {
        logic [15:0] sequence_number;
        logic [31:0] arrival_ms;
    } rsgm_pkt_t;

    // One result record, already cut to the field widths.
    typedef struct packed {
        logic [31:0] packet_count;
        logic [31:0] lost_count;
        logic [31:0] duplicate_count;
        logic [31:0] reorder_count;
        logic [31:0] gap_count;
        logic [31:0] lossy_gap_count;
        logic [31:0] clean_gap_count;
        logic [31:0] recent_gap_ms;
        logic [31:0] longest_gap_ms;
        logic        recent_gap_lossy;
        logic [1:0]  gap_event;
    } rsgm_result_t;

endpackage

### sv/rtp_sequence_gap_monitor_unit.sv
// Top level of the sequence gap monitor: ports, threshold register and result register.
// Instantiates rsgm_input_reg and rsgm_update; depends on rsgm_pkg.
//
// Channel   Direction  Handshake               Contents
// pkt       in         pkt_valid / pkt_ready   sequence_number, arrival_ms
// res       out        res_valid / res_ready   counters, gap lengths, gap_event
// cfg       in         cfg_we                  cfg_wdata -> gap threshold in ms
//
// One packet per cycle is sustained while results are taken; each packet passes
// the input register, then the update into the result register, before its result appears.
// The state update is a single compare and add pass, so it sets the clock.
// A stalled result holds the pipeline; a packet is still taken while the
// input register is empty. Reset clears all counters and sets the threshold to 1000.
module rtp_sequence_gap_monitor_unit #(
    parameter int COUNTER_WIDTH = 32,
    parameter int TIME_WIDTH    = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pkt_valid,
    output logic        pkt_ready,
    input  logic [15:0] sequence_number,
    input  logic [31:0] arrival_ms,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [31:0] packet_count,
    output logic [31:0] lost_count,
    output logic [31:0] duplicate_count,
    output logic [31:0] reorder_count,
    output logic [31:0] gap_count,
    output logic [31:0] lossy_gap_count,
    output logic [31:0] clean_gap_count,
    output logic [31:0] recent_gap_ms,
    output logic [31:0] longest_gap_ms,
    output logic        recent_gap_lossy,
    output logic [1:0]  gap_event,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);
    import rsgm_pkg::*;

    localparam logic [15:0] THRESHOLD_RESET = 16'd1000;

    logic         held_valid;
    rsgm_pkt_t    held_pkt;
    logic         step;
    logic         res_free;
    rsgm_result_t update_result;
    rsgm_result_t result_reg;
    logic         res_valid_reg;
    logic [15:0]  threshold_reg;

    // The update runs when a packet is held and the result register can take it.
    assign res_free = !res_valid_reg || res_ready;
    assign step     = held_valid && res_free;

    // Input register.
    rsgm_input_reg u_input (
        .clk             (clk),
        .rst_n           (rst_n),
        .pkt_valid       (pkt_valid),
        .pkt_ready       (pkt_ready),
        .sequence_number (sequence_number),
        .arrival_ms      (arrival_ms),
        .take            (step),
        .held_valid      (held_valid),
        .held_pkt        (held_pkt)
    );

    // Tracking state and update logic.
    rsgm_update #(
        .COUNTER_WIDTH (COUNTER_WIDTH),
        .TIME_WIDTH    (TIME_WIDTH)
    ) u_update (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (step),
        .pkt              (held_pkt),
        .gap_threshold_ms (threshold_reg),
        .result           (update_result)
    );

    // Gap threshold register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            threshold_reg <= cfg_wdata;
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_free)
        begin
            res_valid_reg <= step;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            result_reg <= update_result;
        end
    end

    assign res_valid        = res_valid_reg;
    assign packet_count     = result_reg.packet_count;
    assign lost_count       = result_reg.lost_count;
    assign duplicate_count  = result_reg.duplicate_count;
    assign reorder_count    = result_reg.reorder_count;
    assign gap_count        = result_reg.gap_count;
    assign lossy_gap_count  = result_reg.lossy_gap_count;
    assign clean_gap_count  = result_reg.clean_gap_count;
    assign recent_gap_ms    = result_reg.recent_gap_ms;
    assign longest_gap_ms   = result_reg.longest_gap_ms;
    assign recent_gap_lossy = result_reg.recent_gap_lossy;
    assign gap_event        = result_reg.gap_event;

    // A held packet with a free result register always moves on.
    a_no_stall_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (held_valid && !res_valid_reg) |=> res_valid_reg)
        else $error("held packet did not produce a result");

    // A stalled result is not overwritten by a new update.
    a_stall_blocks_update: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_ready) |-> !step)
        else $error("update ran while result stalled");

    // A result that is not taken keeps the same packet count.
    a_stall_keeps_result: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_ready) |=> (packet_count == $past(packet_count)))
        else $error("stalled result changed");

endmodule

### sv/rsgm_input_reg.sv
// Input register of the sequence gap monitor.
// Captures one packet per transfer and holds it until the update stage takes it.
// Depends on rsgm_pkg.
module rsgm_input_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pkt_valid,
    output logic              pkt_ready,
    input  logic [15:0]       sequence_number,
    input  logic [31:0]       arrival_ms,
    input  logic              take,
    output logic              held_valid,
    output rsgm_pkg::rsgm_pkt_t held_pkt
);
    import rsgm_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    rsgm_pkt_t  pkt_reg;

    // The register can take a packet when empty or when its content leaves.
    assign pkt_ready  = !valid_reg || take;
    assign valid_next = (pkt_valid && pkt_ready) || (valid_reg && !take);

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, loaded on each input transfer.
    always_ff @(posedge clk)
    begin
        if (pkt_valid && pkt_ready)
        begin
            pkt_reg.sequence_number <= sequence_number;
            pkt_reg.arrival_ms      <= arrival_ms;
        end
    end

    assign held_valid = valid_reg;
    assign held_pkt   = pkt_reg;

endmodule

### sv/rsgm_update.sv
// Tracking state and per-packet update of the sequence gap monitor.
// Classifies the sequence distance, measures silence and updates the counters.
// Depends on rsgm_pkg.
module rsgm_update #(
    parameter int COUNTER_WIDTH = 32,
    parameter int TIME_WIDTH    = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  rsgm_pkg::rsgm_pkt_t    pkt,
    input  logic [15:0]            gap_threshold_ms,
    output rsgm_pkg::rsgm_result_t result
);
    import rsgm_pkg::*;

    localparam int CW = COUNTER_WIDTH;
    localparam int TW = TIME_WIDTH;

    logic [15:0]   expected_seq_reg,   expected_seq_next;
    logic          seq_valid_reg,      seq_valid_next;
    logic [TW-1:0] prev_arrival_reg,   prev_arrival_next;
    logic          arrival_valid_reg,  arrival_valid_next;
    logic [CW-1:0] packets_reg,        packets_next;
    logic [CW-1:0] lost_reg,           lost_next;
    logic [CW-1:0] dup_reg,            dup_next;
    logic [CW-1:0] reorder_reg,        reorder_next;
    logic [CW-1:0] gaps_reg,           gaps_next;
    logic [CW-1:0] lossy_reg,          lossy_next;
    logic [CW-1:0] clean_reg,          clean_next;
    logic [TW-1:0] last_gap_reg,       last_gap_next;
    logic [TW-1:0] worst_gap_reg,      worst_gap_next;
    logic          last_loss_reg,      last_loss_next;

    logic [15:0]   seq_delta;
    logic          hole;
    logic          dup_hit;
    logic          reorder_hit;
    logic [TW-1:0] now;
    logic [TW-1:0] silence;
    logic [TW-1:0] threshold;
    logic          gap_hit;
    logic [CW:0]   lost_sum;
    logic [64:0]   delta_wide;
    logic [1:0]    event_code;

    // Saturating increment of one counter.
    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        return (v == {CW{1'b1}}) ? v : v + {{(CW-1){1'b0}}, 1'b1};
    endfunction

    // Counter value cut or extended to a 32-bit result field.
    function automatic logic [31:0] cnt_field(input logic [CW-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[31:0];
    endfunction

    // Time value cut or extended to a 32-bit result field.
    function automatic logic [31:0] time_field(input logic [TW-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[31:0];
    endfunction

    // Sequence distance classification on the signed 16-bit wrap.
    always_comb
    begin
        seq_delta   = pkt.sequence_number - expected_seq_reg;
        hole        = seq_valid_reg && (seq_delta != 16'd0) && !seq_delta[15];
        dup_hit     = seq_valid_reg && (seq_delta == DIST_DUPLICATE);
        reorder_hit = seq_valid_reg && seq_delta[15] && (seq_delta != DIST_DUPLICATE);
        delta_wide  = 65'(seq_delta);
        lost_sum    = {1'b0, lost_reg} + delta_wide[CW:0];
    end

    // Silence since the previous arrival and the gap decision.
    always_comb
    begin
        logic [63:0] arr_wide;
        logic [63:0] thr_wide;
        arr_wide  = 64'(pkt.arrival_ms);
        thr_wide  = 64'(gap_threshold_ms);
        now       = arr_wide[TW-1:0];
        threshold = thr_wide[TW-1:0];
        silence   = arrival_valid_reg ? (now - prev_arrival_reg) : '0;
        gap_hit   = (silence >= threshold);
    end

    // Next state of every tracking register.
    always_comb
    begin
        expected_seq_next  = pkt.sequence_number + 16'd1;
        seq_valid_next     = 1'b1;
        prev_arrival_next  = now;
        arrival_valid_next = 1'b1;
        packets_next       = sat_inc(packets_reg);
        lost_next          = lost_reg;
        dup_next           = dup_reg;
        reorder_next       = reorder_reg;
        gaps_next          = gaps_reg;
        lossy_next         = lossy_reg;
        clean_next         = clean_reg;
        last_gap_next      = last_gap_reg;
        worst_gap_next     = worst_gap_reg;
        last_loss_next     = last_loss_reg;
        event_code         = GAP_NONE;

        if (hole)
        begin
            lost_next = lost_sum[CW] ? {CW{1'b1}} : lost_sum[CW-1:0];
        end
        if (dup_hit)
        begin
            dup_next = sat_inc(dup_reg);
        end
        if (reorder_hit)
        begin
            reorder_next = sat_inc(reorder_reg);
        end

        if (gap_hit)
        begin
            gaps_next      = sat_inc(gaps_reg);
            last_gap_next  = silence;
            last_loss_next = hole;
            if (silence > worst_gap_reg)
            begin
                worst_gap_next = silence;
            end
            if (hole)
            begin
                lossy_next = sat_inc(lossy_reg);
                event_code = GAP_LOSSY;
            end
            else
            begin
                clean_next = sat_inc(clean_reg);
                event_code = GAP_CLEAN;
            end
        end
    end

    // Tracking registers, advanced once per packet.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_seq_reg  <= '0;
            seq_valid_reg     <= 1'b0;
            prev_arrival_reg  <= '0;
            arrival_valid_reg <= 1'b0;
            packets_reg       <= '0;
            lost_reg          <= '0;
            dup_reg           <= '0;
            reorder_reg       <= '0;
            gaps_reg          <= '0;
            lossy_reg         <= '0;
            clean_reg         <= '0;
            last_gap_reg      <= '0;
            worst_gap_reg     <= '0;
            last_loss_reg     <= 1'b0;
        end
        else if (step)
        begin
            expected_seq_reg  <= expected_seq_next;
            seq_valid_reg     <= seq_valid_next;
            prev_arrival_reg  <= prev_arrival_next;
            arrival_valid_reg <= arrival_valid_next;
            packets_reg       <= packets_next;
            lost_reg          <= lost_next;
            dup_reg           <= dup_next;
            reorder_reg       <= reorder_next;
            gaps_reg          <= gaps_next;
            lossy_reg         <= lossy_next;
            clean_reg         <= clean_next;
            last_gap_reg      <= last_gap_next;
            worst_gap_reg     <= worst_gap_next;
            last_loss_reg     <= last_loss_next;
        end
    end

    // Result record built from the updated state.
    always_comb
    begin
        result.packet_count     = cnt_field(packets_next);
        result.lost_count       = cnt_field(lost_next);
        result.duplicate_count  = cnt_field(dup_next);
        result.reorder_count    = cnt_field(reorder_next);
        result.gap_count        = cnt_field(gaps_next);
        result.lossy_gap_count  = cnt_field(lossy_next);
        result.clean_gap_count  = cnt_field(clean_next);
        result.recent_gap_ms    = time_field(last_gap_next);
        result.longest_gap_ms   = time_field(worst_gap_next);
        result.recent_gap_lossy = last_loss_next;
        result.gap_event        = event_code;
    end

    // The worst gap never falls below the most recent one.
    a_worst_covers_last: assert property (@(posedge clk) disable iff (!rst_n)
        worst_gap_reg >= last_gap_reg)
        else $error("longest gap below most recent gap");

    // Every processed packet leaves a nonzero packet count.
    a_packet_counted: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> (packets_reg != '0))
        else $error("packet count still zero after a packet");

    // A gap with a sequence hole marks the recent gap as lossy.
    a_lossy_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (step && gap_hit && hole) |=> (last_loss_reg && (lossy_reg != '0)))
        else $error("lossy gap not recorded");

    // The first packet after reset never counts as lost.
    a_first_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !seq_valid_reg) |=> (lost_reg == $past(lost_reg)))
        else $error("first packet changed the lost count");

endmodule
